>>> design/lsm_pkg.sv
// Package for the luminaire sample metrics block: field widths, reset
// constants, register indexes, beat payload types and divider status type.
// No dependencies.
`default_nettype none

package lsm_pkg;

  // Field widths
  localparam int unsigned LUX_W      = 20;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned POWER_W    = 12;
  localparam int unsigned ENERGY_W   = 40;
  localparam int unsigned SHORT_W    = 44;
  localparam int unsigned DIFF_W     = 46;
  localparam int unsigned OUT24_W    = 24;
  localparam int unsigned CNT_EXT_W  = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_OCCUPIED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_REFERENCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNOCC_REFERENCE = 2'd2;

  // Reset values
  localparam logic [LUX_W-1:0] LOWEST_RESET    = 20'd320000;
  localparam logic [LUX_W-1:0] OCC_REF_RESET   = 20'd4800;
  localparam logic [LUX_W-1:0] UNOCC_REF_RESET = 20'd1600;

  // Parameter defaults
  localparam int unsigned SAMPLE_PERIOD_MS_DEF = 10;
  localparam int unsigned COUNT_BITS_DEF       = 24;

  // Item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [LUX_W-1:0]  lux;
    logic [DUTY_W-1:0] duty;
    logic [LUX_W-1:0]  external_lux;
  } lsm_in_t;

  typedef struct packed {
    logic [POWER_W-1:0]  power;
    logic [ENERGY_W-1:0] energy;
    logic [LUX_W-1:0]    lowest_lux;
    logic [LUX_W-1:0]    comfort_error;
    logic [OUT24_W-1:0]  flicker;
    logic [OUT24_W-1:0]  sample_count;
    logic [LUX_W-1:0]    external_out;
  } lsm_out_t;

  // Status of a serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> design/lsm_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on lsm_pkg for the payload types.
`default_nettype none

interface lsm_in_if;
  import lsm_pkg::*;

  logic    valid;
  logic    ready;
  lsm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsm_out_if;
  import lsm_pkg::*;

  logic     valid;
  logic     ready;
  lsm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/lsm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle until all NUM_W quotient bits are formed.
// Depends on lsm_pkg for the status struct.
`default_nettype none

module lsm_div #(
  parameter int unsigned NUM_W = 44,
  parameter int unsigned DEN_W = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [DEN_W-1:0]      den_i,
  output lsm_pkg::div_stat_t    stat_o,
  output logic [NUM_W-1:0]      quot_o
);
  import lsm_pkg::*;

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  shf_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // Shift the next numerator bit into the partial remainder and try the divisor.
  assign trial = {rem_q, shf_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  // Step counter and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(NUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // The numerator shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shf_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      shf_q <= {shf_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = shf_q;

endmodule

`default_nettype wire

>>> design/luminaire_sample_metrics_core.sv
// Luminaire sample metrics core: a sample beat updates power, energy, lowest
// lux, comfort error and flicker; a clear beat restarts the metrics.
// A sample beat goes through the start and divide steps, its result held back by the
// 50-step bit-serial flicker divider; a clear beat goes straight to the output step.
// One beat is in work at a time; a finished result waits in the output register.
// Reset (asynchronous, active low) clears all state but the divider datapath.
`default_nettype none

module luminaire_sample_metrics_core #(
  parameter int unsigned SAMPLE_PERIOD_MS = lsm_pkg::SAMPLE_PERIOD_MS_DEF,
  parameter int unsigned COUNT_BITS       = lsm_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lsm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  lsm_in_if.sink                          sample_i,
  lsm_out_if.source                       result_o
);
  import lsm_pkg::*;

  localparam int unsigned E_W       = DUTY_W + $clog2(SAMPLE_PERIOD_MS + 1);
  localparam int unsigned PSQ       = SAMPLE_PERIOD_MS * SAMPLE_PERIOD_MS;
  localparam int unsigned PSQ_W     = $clog2(PSQ + 1);
  localparam int unsigned FLK_NUM_W = DIFF_W + 4;
  localparam int unsigned FLK_DEN_W = COUNT_BITS + PSQ_W;

  typedef enum logic [1:0] {ST_IDLE, ST_START, ST_DIV, ST_OUT} state_e;

  state_e state_q;
  logic   out_valid_q;
  lsm_out_t out_q;

  // Configuration registers
  logic             occ_q;
  logic [LUX_W-1:0] occ_ref_q;
  logic [LUX_W-1:0] unocc_ref_q;

  // Metric state
  logic [LUX_W-1:0]      hist0_q, hist0_d;
  logic [LUX_W-1:0]      hist1_q, hist1_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [ENERGY_W-1:0]   energy_q, energy_d;
  logic [LUX_W-1:0]      lowest_q, lowest_d;
  logic [SHORT_W-1:0]    short_q, short_d;
  logic [DIFF_W-1:0]     diff_q, diff_d;
  logic [LUX_W-1:0]      ext_q, ext_d;
  logic [POWER_W-1:0]    power_q, power_d;
  logic                  cmf_en_q, cmf_en_d;
  logic                  flk_en_q, flk_en_d;

  logic                  accept;
  logic                  out_free;
  logic [E_W-1:0]        e_val;
  logic [ENERGY_W-1:0]   e_ext;
  logic [ENERGY_W:0]     energy_sum;
  logic [LUX_W-1:0]      ref_lux;
  logic [SHORT_W:0]      short_sum;
  logic [LUX_W:0]        pos_val;
  logic [LUX_W:0]        neg_val;
  logic [LUX_W:0]        d_val;
  logic [DIFF_W:0]       diff_sum;
  logic [COUNT_BITS-1:0] cnt_inc;

  logic                  div_start;
  div_stat_t             cmf_stat;
  div_stat_t             flk_stat;
  logic [SHORT_W-1:0]    cmf_quot;
  logic [FLK_NUM_W-1:0]  flk_quot;
  logic [FLK_DEN_W-1:0]  flk_den;
  logic [LUX_W-1:0]      comfort;
  logic [OUT24_W-1:0]    flicker;
  logic [CNT_EXT_W-1:0]  cnt_ext;
  logic [OUT24_W-1:0]    count_out;

  assign accept   = sample_i.valid && sample_i.ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign sample_i.ready = (state_q == ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= 1'b0;
      occ_ref_q   <= OCC_REF_RESET;
      unocc_ref_q <= UNOCC_REF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OCCUPIED:        occ_q       <= cfg_data_i[0];
        CFG_OCC_REFERENCE:   occ_ref_q   <= cfg_data_i[LUX_W-1:0];
        CFG_UNOCC_REFERENCE: unocc_ref_q <= cfg_data_i[LUX_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-sample arithmetic on the accepted beat.
  assign e_val      = E_W'(sample_i.data.duty) * E_W'(SAMPLE_PERIOD_MS);
  assign e_ext      = ENERGY_W'(e_val);
  assign energy_sum = {1'b0, energy_q} + {1'b0, e_ext};
  assign ref_lux    = occ_q ? occ_ref_q : unocc_ref_q;
  assign short_sum  = {1'b0, short_q}
                    + (SHORT_W + 1)'(ref_lux - sample_i.data.lux);
  assign pos_val    = {1'b0, sample_i.data.lux} + {1'b0, hist1_q};
  assign neg_val    = {hist0_q, 1'b0};
  assign d_val      = (pos_val >= neg_val) ? pos_val - neg_val : neg_val - pos_val;
  assign diff_sum   = {1'b0, diff_q} + (DIFF_W + 1)'(d_val);
  assign cnt_inc    = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  // Next metric state for a sample or a clear beat.
  always_comb begin
    hist0_d  = hist0_q;
    hist1_d  = hist1_q;
    cnt_d    = cnt_q;
    energy_d = energy_q;
    lowest_d = lowest_q;
    short_d  = short_q;
    diff_d   = diff_q;
    ext_d    = ext_q;
    power_d  = power_q;
    cmf_en_d = cmf_en_q;
    flk_en_d = flk_en_q;
    if (accept) begin
      if (sample_i.data.opcode == OP_CLEAR) begin
        hist0_d  = '0;
        hist1_d  = '0;
        cnt_d    = '0;
        energy_d = '0;
        lowest_d = LOWEST_RESET;
        short_d  = '0;
        diff_d   = '0;
        power_d  = '0;
        cmf_en_d = 1'b0;
        flk_en_d = 1'b0;
      end else begin
        hist0_d  = sample_i.data.lux;
        hist1_d  = hist0_q;
        cnt_d    = cnt_inc;
        energy_d = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
        if (sample_i.data.lux < lowest_q) begin
          lowest_d = sample_i.data.lux;
        end
        if (ref_lux > sample_i.data.lux) begin
          short_d = short_sum[SHORT_W] ? '1 : short_sum[SHORT_W-1:0];
        end
        flk_en_d = (cnt_inc >= COUNT_BITS'(3));
        if (flk_en_d) begin
          diff_d = diff_sum[DIFF_W] ? '1 : diff_sum[DIFF_W-1:0];
        end
        ext_d    = sample_i.data.external_lux;
        power_d  = (e_ext > ENERGY_W'({POWER_W{1'b1}})) ? '1 : e_ext[POWER_W-1:0];
        cmf_en_d = 1'b1;
      end
    end
  end

  // Metric registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist0_q  <= '0;
      hist1_q  <= '0;
      cnt_q    <= '0;
      energy_q <= '0;
      lowest_q <= LOWEST_RESET;
      short_q  <= '0;
      diff_q   <= '0;
      ext_q    <= '0;
      power_q  <= '0;
      cmf_en_q <= 1'b0;
      flk_en_q <= 1'b0;
    end else begin
      hist0_q  <= hist0_d;
      hist1_q  <= hist1_d;
      cnt_q    <= cnt_d;
      energy_q <= energy_d;
      lowest_q <= lowest_d;
      short_q  <= short_d;
      diff_q   <= diff_d;
      ext_q    <= ext_d;
      power_q  <= power_d;
      cmf_en_q <= cmf_en_d;
      flk_en_q <= flk_en_d;
    end
  end

  // Divisor for flicker: count times the squared period, registered in the divider.
  assign div_start = (state_q == ST_START);
  assign flk_den   = FLK_DEN_W'(cnt_q) * FLK_DEN_W'(PSQ);

  lsm_div #(
    .NUM_W (SHORT_W),
    .DEN_W (COUNT_BITS)
  ) u_cmf_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (short_q),
    .den_i   (cnt_q),
    .stat_o  (cmf_stat),
    .quot_o  (cmf_quot)
  );

  lsm_div #(
    .NUM_W (FLK_NUM_W),
    .DEN_W (FLK_DEN_W)
  ) u_flk_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({diff_q, 4'b0000}),
    .den_i   (flk_den),
    .stat_o  (flk_stat),
    .quot_o  (flk_quot)
  );

  // Saturate the quotients and the count to their field widths.
  always_comb begin
    comfort = '0;
    flicker = '0;
    if (cmf_en_q) begin
      comfort = (cmf_quot[SHORT_W-1:LUX_W] != '0) ? '1 : cmf_quot[LUX_W-1:0];
    end
    if (flk_en_q) begin
      flicker = (flk_quot[FLK_NUM_W-1:OUT24_W] != '0) ? '1 : flk_quot[OUT24_W-1:0];
    end
  end

  assign cnt_ext   = CNT_EXT_W'(cnt_q);
  assign count_out = (cnt_ext > CNT_EXT_W'({OUT24_W{1'b1}})) ? '1 : cnt_ext[OUT24_W-1:0];

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // A taken result empties the output register unless the output step refills it.
      if (out_valid_q && result_o.ready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= (sample_i.data.opcode == OP_CLEAR) ? ST_OUT : ST_START;
          end
        end
        ST_START: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cmf_stat.done && flk_stat.done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q         <= 1'b1;
            out_q.power         <= power_q;
            out_q.energy        <= energy_q;
            out_q.lowest_lux    <= lowest_q;
            out_q.comfort_error <= comfort;
            out_q.flicker       <= flicker;
            out_q.sample_count  <= count_out;
            out_q.external_out  <= ext_q;
            state_q             <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // A result beat only appears after the output step of the sequencer.
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result appeared outside the output step");

  // A clear beat restarts the count and the lowest lux.
  a_clear_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && sample_i.data.opcode == OP_CLEAR |=> cnt_q == '0 && lowest_q == LOWEST_RESET)
    else $error("clear beat did not restart the metrics");

  // The lowest lux never climbs above its restart value.
  a_lowest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lowest_q <= LOWEST_RESET)
    else $error("lowest lux above restart value");

  // The dividers are quiet whenever the block can take a new beat.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !cmf_stat.busy && !flk_stat.busy)
    else $error("divider busy while idle");

endmodule

`default_nettype wire

>>> sim/luminaire_sample_metrics_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for luminaire_sample_metrics_core: random and directed
// sample and clear beats, with results checked against an in-bench metrics model.
// Depends on lsm_pkg, lsm_if and the core RTL.

module luminaire_sample_metrics_core_tb;
  import lsm_pkg::*;

  localparam int unsigned PERIOD_MS      = SAMPLE_PERIOD_MS_DEF;
  localparam int unsigned CNT_BITS       = COUNT_BITS_DEF;
  localparam int unsigned LUX_TOP        = (1 << LUX_W) - 1;
  localparam int unsigned DUTY_TOP       = (1 << DUTY_W) - 1;
  localparam longint unsigned CNT_SAT    = (64'd1 << CNT_BITS) - 1;
  localparam longint unsigned ENERGY_SAT = (64'd1 << ENERGY_W) - 1;
  localparam longint unsigned SHORT_SAT  = (64'd1 << SHORT_W) - 1;
  localparam longint unsigned DIFF_SAT   = (64'd1 << DIFF_W) - 1;
  localparam longint unsigned OUT24_SAT  = (64'd1 << OUT24_W) - 1;
  localparam longint unsigned POWER_SAT  = (64'd1 << POWER_W) - 1;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned MAX_PRINTED    = 30;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = CFG_OCCUPIED;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  lsm_in_if  sample_if ();
  lsm_out_if result_if ();

  // Traffic knobs, changed on the falling edge only.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          rx_hold        = 1'b0;
  bit          hold_armed     = 1'b0;

  // Beats waiting to be offered and metrics waiting to come back.
  lsm_in_t  sample_beats_q[$];
  lsm_out_t expected_metrics_q[$];
  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;

  // Metrics model: register copies and per-luminaire state.
  bit                  occupied_cfg;
  bit [LUX_W-1:0]      occ_ref_cfg;
  bit [LUX_W-1:0]      unocc_ref_cfg;
  bit [LUX_W-1:0]      lux_prev;
  bit [LUX_W-1:0]      lux_prev2;
  bit [CNT_BITS-1:0]   samples_seen;
  bit [ENERGY_W-1:0]   energy_acc;
  bit [LUX_W-1:0]      lowest_lux_seen;
  bit [SHORT_W-1:0]    shortfall_acc;
  bit [DIFF_W-1:0]     second_diff_acc;
  bit [LUX_W-1:0]      external_last;
  bit [LUX_W-1:0]      lux_walk = '0;

  luminaire_sample_metrics_core #(
    .SAMPLE_PERIOD_MS(PERIOD_MS),
    .COUNT_BITS      (CNT_BITS)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .sample_i  (sample_if),
    .result_o  (result_if)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    result_if.ready = 1'b0;
  end

  // Appends a beat to the queue of beats still to be offered.
  function automatic void add_beat(lsm_in_t b);
    sample_beats_q.insert(sample_beats_q.size(), b);
  endfunction

  // Appends the metrics that the next result beat must carry.
  function automatic void add_expected(lsm_out_t m);
    expected_metrics_q.insert(expected_metrics_q.size(), m);
  endfunction

  // A clear beat restarts every metric but keeps the external reading.
  function automatic void clear_metric_state();
    lux_prev        = '0;
    lux_prev2       = '0;
    samples_seen    = '0;
    energy_acc      = '0;
    lowest_lux_seen = LOWEST_RESET;
    shortfall_acc   = '0;
    second_diff_acc = '0;
  endfunction

  // Applies one accepted beat to the model and returns the metrics it reports.
  function automatic lsm_out_t update_luminaire_metrics(lsm_in_t beat);
    lsm_out_t        res;
    bit [LUX_W-1:0]  ref_lux;
    longint unsigned energy_step;
    longint unsigned sum;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned diff;
    longint unsigned denom;
    longint unsigned quot;
    res = '0;
    if (beat.opcode == OP_CLEAR) begin
      clear_metric_state();
    end else begin
      ref_lux     = occupied_cfg ? occ_ref_cfg : unocc_ref_cfg;
      energy_step = 64'(beat.duty) * PERIOD_MS;
      if (64'(samples_seen) < CNT_SAT) samples_seen = samples_seen + 1'b1;

      res.power     = (energy_step > POWER_SAT) ? '1 : POWER_W'(energy_step);
      sum           = 64'(energy_acc) + energy_step;
      energy_acc    = (sum > ENERGY_SAT) ? '1 : ENERGY_W'(sum);
      external_last = beat.external_lux;
      if (beat.lux < lowest_lux_seen) lowest_lux_seen = beat.lux;

      // Only a lux below the reference adds to the shortfall.
      if (ref_lux > beat.lux) begin
        sum           = 64'(shortfall_acc) + 64'(ref_lux - beat.lux);
        shortfall_acc = (sum > SHORT_SAT) ? '1 : SHORT_W'(sum);
      end
      quot              = 64'(shortfall_acc) / 64'(samples_seen);
      res.comfort_error = (quot > 64'(LUX_TOP)) ? '1 : LUX_W'(quot);

      // Second differences need two earlier samples since the last clear.
      if (samples_seen >= 3) begin
        pos             = 64'(beat.lux) + 64'(lux_prev2);
        neg             = 64'(lux_prev) * 2;
        diff            = (pos >= neg) ? pos - neg : neg - pos;
        denom           = 64'(samples_seen) * PERIOD_MS * PERIOD_MS;
        sum             = 64'(second_diff_acc) + diff;
        second_diff_acc = (sum > DIFF_SAT) ? '1 : DIFF_W'(sum);
        quot            = (64'(second_diff_acc) * 16) / denom;
        res.flicker     = (quot > OUT24_SAT) ? '1 : OUT24_W'(quot);
      end
      lux_prev2 = lux_prev;
      lux_prev  = beat.lux;
    end
    res.energy       = energy_acc;
    res.lowest_lux   = lowest_lux_seen;
    res.sample_count = (64'(samples_seen) > OUT24_SAT) ? '1 : OUT24_W'(samples_seen);
    res.external_out = external_last;
    return res;
  endfunction

  function automatic lsm_in_t make_beat(logic op, int unsigned lux, int unsigned duty,
                                        int unsigned ext);
    lsm_in_t b;
    b.opcode       = op;
    b.lux          = LUX_W'(lux);
    b.duty         = DUTY_W'(duty);
    b.external_lux = LUX_W'(ext);
    return b;
  endfunction

  function automatic int clamp_lux(int v);
    if (v < 0) return 0;
    if (v > int'(LUX_TOP)) return int'(LUX_TOP);
    return v;
  endfunction

  // Mostly sample beats in long runs between rare clears; lux is drawn from the
  // extremes, near the active reference, a slow walk or the full range.
  function automatic lsm_in_t random_beat();
    lsm_in_t        b;
    bit [LUX_W-1:0] ref_lux;
    int             v;
    ref_lux  = occupied_cfg ? occ_ref_cfg : unocc_ref_cfg;
    b.opcode = ($urandom_range(99) < 3) ? OP_CLEAR : OP_SAMPLE;
    case ($urandom_range(9))
      0:       v = 0;
      1:       v = int'(LUX_TOP);
      2, 3:    v = clamp_lux(int'(ref_lux) + int'($urandom_range(64)) - 32);
      4, 5, 6: v = clamp_lux(int'(lux_walk) + int'($urandom_range(400)) - 200);
      default: v = int'($urandom_range(LUX_TOP));
    endcase
    b.lux    = LUX_W'(v);
    lux_walk = b.lux;
    case ($urandom_range(7))
      0:       b.duty = '0;
      1:       b.duty = '1;
      default: b.duty = DUTY_W'($urandom_range(DUTY_TOP));
    endcase
    case ($urandom_range(7))
      0:       b.external_lux = '0;
      1:       b.external_lux = '1;
      default: b.external_lux = LUX_W'($urandom_range(LUX_TOP));
    endcase
    return b;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t ns: result %0d %s: got %0d, expected %0d",
               $realtime, results_checked, what, got, want);
  endtask

  task automatic check_result(lsm_out_t got);
    lsm_out_t want;
    results_checked++;
    if (expected_metrics_q.size() == 0) begin
      report_mismatch("arrived with no sample beat pending", 0, 0);
      return;
    end
    want = expected_metrics_q.pop_front();
    if (got.power != want.power) report_mismatch("power", got.power, want.power);
    if (got.energy != want.energy) report_mismatch("energy", got.energy, want.energy);
    if (got.lowest_lux != want.lowest_lux)
      report_mismatch("lowest_lux", got.lowest_lux, want.lowest_lux);
    if (got.comfort_error != want.comfort_error)
      report_mismatch("comfort_error", got.comfort_error, want.comfort_error);
    if (got.flicker != want.flicker) report_mismatch("flicker", got.flicker, want.flicker);
    if (got.sample_count != want.sample_count)
      report_mismatch("sample_count", got.sample_count, want.sample_count);
    if (got.external_out != want.external_out)
      report_mismatch("external_out", got.external_out, want.external_out);
  endtask

  // Sample driver: predicts on each accepted beat, then offers the next one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
    end else begin
      if (sample_if.valid && sample_if.ready)
        add_expected(update_luminaire_metrics(sample_if.data));
      if (!sample_if.valid || sample_if.ready) begin
        if (sample_beats_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_if.valid <= 1'b1;
          sample_if.data  <= sample_beats_q.pop_front();
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted beat and stalls at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) check_result(result_if.data);
      result_if.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the core fills up and stalls its input.
  initial begin
    wait (hold_armed);
    @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_OCCUPIED:        occupied_cfg  = value[0];
      CFG_OCC_REFERENCE:   occ_ref_cfg   = LUX_W'(value);
      CFG_UNOCC_REFERENCE: unocc_ref_cfg = LUX_W'(value);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Every beat yields one result, so an empty expectation queue means idle.
  // Checked on the falling edge, once the driver's updates have settled.
  task automatic wait_for_results();
    while (sample_beats_q.size() != 0 || sample_if.valid || expected_metrics_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(bit occ, int unsigned occ_ref, int unsigned unocc_ref,
                           int unsigned send_pct, int unsigned recv_pct,
                           int unsigned beats, bit with_hold);
    write_reg(CFG_OCCUPIED, CFG_DATA_W'(occ));
    write_reg(CFG_OCC_REFERENCE, CFG_DATA_W'(occ_ref));
    write_reg(CFG_UNOCC_REFERENCE, CFG_DATA_W'(unocc_ref));
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (with_hold) hold_armed = 1'b1;
    repeat (beats) add_beat(random_beat());
    wait_for_results();
  endtask

  // Main sequence: reset, directed beats, then random phases.
  initial begin
    occupied_cfg  = 1'b0;
    occ_ref_cfg   = OCC_REF_RESET;
    unocc_ref_cfg = UNOCC_REF_RESET;
    external_last = '0;
    clear_metric_state();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats at reset configuration (unoccupied reference of 1600 lux).
    add_beat(make_beat(OP_CLEAR, 0, 0, 0));
    add_beat(make_beat(OP_SAMPLE, 0, 0, 0));
    add_beat(make_beat(OP_SAMPLE, LUX_TOP, DUTY_TOP, LUX_TOP));
    add_beat(make_beat(OP_SAMPLE, 0, 128, 'h55555));
    add_beat(make_beat(OP_SAMPLE, LUX_TOP, 1, 'hAAAAA));
    add_beat(make_beat(OP_SAMPLE, UNOCC_REF_RESET, 10, 7));
    add_beat(make_beat(OP_SAMPLE, UNOCC_REF_RESET - 1, 20, 8));
    add_beat(make_beat(OP_SAMPLE, UNOCC_REF_RESET + 1, 30, 9));
    add_beat(make_beat(OP_CLEAR, LUX_TOP, DUTY_TOP, LUX_TOP));
    add_beat(make_beat(OP_SAMPLE, 500, 40, 100));
    add_beat(make_beat(OP_CLEAR, 0, 0, 0));
    add_beat(make_beat(OP_SAMPLE, 300, DUTY_TOP, 200));
    add_beat(make_beat(OP_SAMPLE, LOWEST_RESET, DUTY_TOP, 300));
    add_beat(make_beat(OP_SAMPLE, LOWEST_RESET + 1, 5, 400));
    add_beat(make_beat(OP_CLEAR, 0, 0, 0));
    add_beat(make_beat(OP_SAMPLE, LOWEST_RESET + 1, 6, 500));
    add_beat(make_beat(OP_SAMPLE, LOWEST_RESET - 1, 7, 600));
    add_beat(make_beat(OP_SAMPLE, 1000, 8, 700));
    add_beat(make_beat(OP_SAMPLE, 1000, 9, 800));
    add_beat(make_beat(OP_SAMPLE, 1000, 10, 900));
    add_beat(make_beat(OP_CLEAR, 0, 0, 0));
    add_beat(make_beat(OP_CLEAR, 0, 0, 0));
    wait_for_results();

    // Random phases across register settings and traffic patterns.
    run_phase(1'b1, $urandom_range(LUX_TOP), $urandom_range(LUX_TOP), 0, 0, 250, 1'b0);
    run_phase(1'b0, LUX_TOP, LUX_TOP, 84, 0, 250, 1'b0);
    run_phase(1'b1, 0, 0, 0, 84, 250, 1'b0);
    run_phase(1'b1, LUX_TOP, UNOCC_REF_RESET, 13, 13, 250, 1'b0);
    run_phase(1'b0, OCC_REF_RESET, $urandom_range(LUX_TOP), 0, 0, 150, 1'b1);
    run_phase(1'($urandom_range(1)), $urandom_range(LUX_TOP), $urandom_range(LUX_TOP),
              13, 13, 150, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: a time limit far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
